### rtl/lft_pkg.sv
// Shared types and constants for the line-follow turn controller.
`default_nettype none

package lft_pkg;

  // Sensor groups and mode-logic limits
  localparam logic [7:0] SideLeftMask  = 8'h07;
  localparam logic [7:0] SideRightMask = 8'hE0;
  localparam logic [7:0] MidMask       = 8'h18;
  localparam logic [3:0] HoldLimit     = 4'd15;
  localparam logic [2:0] RecoverTicks  = 3'd3;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgAdvanceTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTurnTimeout  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInnerSpeed   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgOuterSpeed   = 2'd3;

  // Configuration reset values
  localparam logic [7:0]         AdvanceTicksRst = 8'd10;
  localparam logic [15:0]        TurnTimeoutRst  = 16'd2000;
  localparam logic signed [15:0] InnerSpeedRst   = 16'sd0;
  localparam logic signed [15:0] OuterSpeedRst   = 16'sd0;

  typedef enum logic [2:0] {
    MODE_STRAIGHT = 3'd0,
    MODE_DELAY    = 3'd1,
    MODE_LEFT     = 3'd2,
    MODE_RIGHT    = 3'd3,
    MODE_LOST     = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0]         advance_ticks;
    logic [15:0]        turn_limit_ms;
    logic signed [15:0] inner_speed;
    logic signed [15:0] outer_speed;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic               going_straight;
    logic               line_lost;
    logic signed [15:0] left_wheel;
    logic signed [15:0] right_wheel;
  } res_t;

endpackage

`default_nettype wire

### rtl/lft_cfg.sv
// Configuration register bank for the turn controller.
`default_nettype none

module lft_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [lft_pkg::CfgIdxW-1:0]  wr_index,
  input  wire logic [lft_pkg::CfgDataW-1:0] wr_data,
  output lft_pkg::cfg_t                      cfg
);

  lft_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.advance_ticks <= lft_pkg::AdvanceTicksRst;
      regs.turn_limit_ms <= lft_pkg::TurnTimeoutRst;
      regs.inner_speed   <= lft_pkg::InnerSpeedRst;
      regs.outer_speed   <= lft_pkg::OuterSpeedRst;
    end else if (wr_en) begin
      unique case (wr_index)
        lft_pkg::CfgAdvanceTicks: regs.advance_ticks <= wr_data[7:0];
        lft_pkg::CfgTurnTimeout:  regs.turn_limit_ms <= wr_data;
        lft_pkg::CfgInnerSpeed:   regs.inner_speed   <= $signed(wr_data);
        lft_pkg::CfgOuterSpeed:   regs.outer_speed   <= $signed(wr_data);
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

### rtl/lft_core.sv
// Mode state and single-tick next-state logic of the turn controller.
`default_nettype none

module lft_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    bits,
  input  wire logic          line,
  input  wire logic [31:0]   now,
  input  wire lft_pkg::cfg_t cfg,
  output lft_pkg::res_t      res
);

  lft_pkg::mode_t cur_mode, cur_mode_next;
  logic           pending_right, pending_right_next;
  logic           centre_was_lost, centre_was_lost_next;
  logic [31:0]    turn_start_time, turn_start_time_next;
  logic [3:0]     centre_hold_count, centre_hold_count_next;
  logic [1:0]     recovery_count, recovery_count_next;
  logic [7:0]     delay_count, delay_count_next;

  logic           mid_on;
  logic [7:0]     delay_dec;
  logic           lost_upd;
  logic [3:0]     hold_upd;
  logic [31:0]    elapsed;
  logic [2:0]     recover_sum;

  assign mid_on      = |(bits & lft_pkg::MidMask);
  assign delay_dec   = (delay_count != 8'd0) ? delay_count - 8'd1 : 8'd0;
  assign elapsed     = now - turn_start_time;
  assign recover_sum = {1'b0, recovery_count} + 3'd1;

  always_comb begin
    cur_mode_next          = cur_mode;
    pending_right_next     = pending_right;
    centre_was_lost_next   = centre_was_lost;
    turn_start_time_next   = turn_start_time;
    centre_hold_count_next = centre_hold_count;
    recovery_count_next    = recovery_count;
    delay_count_next       = delay_count;
    lost_upd               = centre_was_lost;
    hold_upd               = centre_hold_count;

    unique case (cur_mode) inside
      lft_pkg::MODE_DELAY: begin
        if (!line) begin
          cur_mode_next = lft_pkg::MODE_LOST;
        end else begin
          delay_count_next = delay_dec;
          if (delay_dec == 8'd0) begin
            cur_mode_next          = pending_right ? lft_pkg::MODE_RIGHT : lft_pkg::MODE_LEFT;
            centre_was_lost_next   = 1'b0;
            centre_hold_count_next = 4'd0;
            turn_start_time_next   = now;
          end
        end
      end
      lft_pkg::MODE_LEFT, lft_pkg::MODE_RIGHT: begin
        if (!mid_on) begin
          lost_upd = 1'b1;
          hold_upd = 4'd0;
        end else if (centre_hold_count < lft_pkg::HoldLimit) begin
          hold_upd = centre_hold_count + 4'd1;
        end
        centre_was_lost_next   = lost_upd;
        centre_hold_count_next = hold_upd;
        // Exit on centre recapture once the centre has been lost
        if (lost_upd && (mid_on || hold_upd >= lft_pkg::HoldLimit)) begin
          cur_mode_next          = lft_pkg::MODE_STRAIGHT;
          centre_was_lost_next   = 1'b0;
          centre_hold_count_next = 4'd0;
          turn_start_time_next   = 32'd0;
        end else if (elapsed >= {16'd0, cfg.turn_limit_ms}) begin
          cur_mode_next = lft_pkg::MODE_LOST;
        end
      end
      lft_pkg::MODE_LOST: begin
        if (line) begin
          if (recover_sum >= lft_pkg::RecoverTicks) begin
            cur_mode_next        = lft_pkg::MODE_STRAIGHT;
            turn_start_time_next = 32'd0;
            centre_was_lost_next = 1'b0;
            recovery_count_next  = 2'd0;
          end else begin
            recovery_count_next = recover_sum[1:0];
          end
        end else begin
          recovery_count_next = 2'd0;
        end
      end
      default: begin
        // Straight, and any unused code acts as straight; left wins a tie
        if (!line) begin
          cur_mode_next = lft_pkg::MODE_LOST;
        end else if ((bits & lft_pkg::SideLeftMask) == lft_pkg::SideLeftMask) begin
          cur_mode_next      = lft_pkg::MODE_DELAY;
          pending_right_next = 1'b0;
          delay_count_next   = cfg.advance_ticks;
        end else if ((bits & lft_pkg::SideRightMask) == lft_pkg::SideRightMask) begin
          cur_mode_next      = lft_pkg::MODE_DELAY;
          pending_right_next = 1'b1;
          delay_count_next   = cfg.advance_ticks;
        end
      end
    endcase
  end

  always_comb begin
    res.mode           = cur_mode_next;
    res.going_straight = (cur_mode_next == lft_pkg::MODE_STRAIGHT) ||
                         (cur_mode_next == lft_pkg::MODE_DELAY);
    res.line_lost      = (cur_mode_next == lft_pkg::MODE_LOST);
    res.left_wheel     = 16'sd0;
    res.right_wheel    = 16'sd0;
    if (cur_mode_next == lft_pkg::MODE_LEFT) begin
      res.left_wheel  = cfg.inner_speed;
      res.right_wheel = cfg.outer_speed;
    end else if (cur_mode_next == lft_pkg::MODE_RIGHT) begin
      res.left_wheel  = cfg.outer_speed;
      res.right_wheel = cfg.inner_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode          <= lft_pkg::MODE_STRAIGHT;
      pending_right     <= 1'b0;
      centre_was_lost   <= 1'b0;
      turn_start_time   <= 32'd0;
      centre_hold_count <= 4'd0;
      recovery_count    <= 2'd0;
      delay_count       <= 8'd0;
    end else if (step) begin
      cur_mode          <= cur_mode_next;
      pending_right     <= pending_right_next;
      centre_was_lost   <= centre_was_lost_next;
      turn_start_time   <= turn_start_time_next;
      centre_hold_count <= centre_hold_count_next;
      recovery_count    <= recovery_count_next;
      delay_count       <= delay_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/line_follow_turn_fsm_unit.sv
// Top level of the line-follow turn controller: request registers and result stage.
//
//   channel | signals                                               | dir
//   --------+-------------------------------------------------------+-----
//   cfg     | cfg_valid cfg_ready cfg_index[1:0] cfg_data[15:0]      | in
//   in      | in_valid in_ready sensor_bits line_present time_ms     | in
//   out     | out_valid out_ready mode going_straight line_lost      | out
//           | left_wheel right_wheel                                 |
//
// One request per cycle sustained while out_ready stays high. A request taken into the
// input register runs the mode update as it moves on to the result register, which
// raises out_valid (two register stages). Mode state advances when a request moves
// from the input register to the result register. Synchronous reset puts the mode
// state in straight, the config registers at their defaults and both valids low;
// both readies are low in reset. A stalled result holds both stages; the input
// register takes one more request only while it is empty.
`default_nettype none

module line_follow_turn_fsm_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [lft_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lft_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [7:0]                    sensor_bits,
  input  wire logic                          line_present,
  input  wire logic [31:0]                   time_ms,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [2:0]                    mode,
  output      logic                          going_straight,
  output      logic                          line_lost,
  output      logic signed [15:0]            left_wheel,
  output      logic signed [15:0]            right_wheel
);

  lft_pkg::cfg_t cfg;
  lft_pkg::res_t res;
  lft_pkg::res_t res_q;

  logic        s1_valid;
  logic [7:0]  s1_bits;
  logic        s1_line;
  logic [31:0] s1_time;
  logic        out_free;
  logic        advance;

  assign cfg_ready = !rst;

  lft_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !rst && (!s1_valid || out_free);

  lft_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .bits (s1_bits),
    .line (s1_line),
    .now  (s1_time),
    .cfg  (cfg),
    .res  (res)
  );

  // Input register: take a request whenever the slot is empty or empties this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_bits <= sensor_bits;
      s1_line <= line_present;
      s1_time <= time_ms;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign mode           = res_q.mode;
  assign going_straight = res_q.going_straight;
  assign line_lost      = res_q.line_lost;
  assign left_wheel     = res_q.left_wheel;
  assign right_wheel    = res_q.right_wheel;

endmodule

`default_nettype wire
